// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Overlapping implication.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  `RAU_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
  `RAU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and helpers shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SHIFT_BITS = $clog2(PROD_BITS);
  localparam int CNT_BITS = $clog2(PROD_BITS + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2,
    ST_ZDEN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GST,
    S_GCD,
    S_DVN,
    S_DVD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 neg;
    logic [WORD_BITS-1:0] mag;
  } smag_t;

  typedef struct packed {
    logic                 neg;
    logic [PROD_BITS-1:0] mag;
  } smag_w_t;

  // two's complement word to sign-magnitude, zero is positive
  function automatic smag_t to_smag(logic [WORD_BITS-1:0] v);
    smag_t r;
    r.neg = v[WORD_BITS-1];
    r.mag = r.neg ? (~v + WORD_BITS'(1)) : v;
    return r;
  endfunction

  // signed-magnitude add, magnitudes stay below 2^(PROD_BITS-1) + 1
  function automatic smag_w_t sadd(smag_w_t x, smag_w_t y);
    smag_w_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two nonzero double-width magnitudes, one step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd import rau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_BITS-1:0] a_i,
  input  logic [PROD_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [PROD_BITS-1:0] gcd_o
);

  logic                  run_q, run_d, done_q, done_d;
  logic [PROD_BITS-1:0]  x_q, x_d, y_q, y_d, g_q, g_d;
  logic [SHIFT_BITS-1:0] k_q, k_d;
  logic [PROD_BITS:0]    diff;

  // shared subtract and compare
  assign diff = {1'b0, x_q} - {1'b0, y_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    g_d    = g_q;
    if (start_i) begin
      run_d = 1'b1;
      x_d   = a_i;
      y_d   = b_i;
      k_d   = '0;
    end else if (run_q) begin
      priority if (x_q == '0) begin
        g_d    = y_q << k_q;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + SHIFT_BITS'(1);
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (!diff[PROD_BITS]) begin
        x_d = diff[PROD_BITS-1:0];
      end else begin
        y_d = ~diff[PROD_BITS-1:0] + PROD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

// File: hdl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_BITS-1:0] dividend_i,
  input  logic [PROD_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [PROD_BITS-1:0] quot_o
);

  logic                 run_q, run_d, done_q, done_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [PROD_BITS-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [PROD_BITS:0]   shifted;
  logic [PROD_BITS+1:0] diff;

  assign shifted = {rem_q, quo_q[PROD_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = diff[PROD_BITS+1] ? shifted[PROD_BITS-1:0] : diff[PROD_BITS-1:0];
      quo_d = {quo_q[PROD_BITS-2:0], ~diff[PROD_BITS+1]};
      cnt_d = cnt_q + CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(PROD_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/sub/mul/div of two signed fractions, reduced by their gcd.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry op and the two fractions.
//   A beat is taken when in_valid_i is high and in_stall_o is low.
//   in_stall_o is high from the accepted beat until the result has moved
//   into the output register.
//   Output channel: out_valid_o / out_stall_i carry the reduced fraction,
//   status and the raw operand-equality flag. A stalled result holds.
//   Error cases (zero denominator, divide by zero) go straight to the final
//   state. A zero numerator skips the gcd and the divider. Otherwise the
//   multiplier steps S_MUL0, S_MUL1 and S_MUL2, one sum, the binary gcd
//   (one step per cycle) and two divider passes run in order, with one beat
//   in flight at a time.
//   A new beat can be taken while the previous result still waits on
//   out_stall_i; the block then waits in its final state for the slot.
//   Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [WORD_BITS-1:0] lhs_num_i,
  input  logic [WORD_BITS-1:0] lhs_den_i,
  input  logic [WORD_BITS-1:0] rhs_num_i,
  input  logic [WORD_BITS-1:0] rhs_den_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] res_num_o,
  output logic [WORD_BITS-2:0] res_den_o,
  output logic [1:0]           status_o,
  output logic                 operands_equal_o
);

  localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (WORD_BITS - 1);

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  smag_t   a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  smag_t   sa, sb, sc, sd;
  smag_w_t p0_q, p0_d, p1_q, p1_d, pd_q, pd_d, num_q, num_d, sum;
  smag_t   mx, my;
  logic [PROD_BITS-1:0] prod, g_q, g_d, qn_q, qn_d, neg_qn;
  logic    eq_q, eq_d;
  status_e st_q, st_d;
  logic [WORD_BITS-1:0] fnum_q, fnum_d;
  logic [WORD_BITS-2:0] fden_q, fden_d;
  logic    ovf;

  logic out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] out_num_q, out_num_d;
  logic [WORD_BITS-2:0] out_den_q, out_den_d;
  status_e out_st_q, out_st_d;
  logic out_eq_q, out_eq_d;

  logic gcd_start, gcd_done, div_start, div_done;
  logic [PROD_BITS-1:0] gcd_g, div_dvd, div_dvs, div_q;

  assign sa = to_smag(lhs_num_i);
  assign sb = to_smag(lhs_den_i);
  assign sc = to_smag(rhs_num_i);
  assign sd = to_smag(rhs_den_i);

  // the one shared multiplier; operands picked per step
  always_comb begin
    unique case (state_q)
      S_MUL0:  begin mx = a_q; my = (op_q == OP_MUL) ? c_q : d_q; end
      S_MUL1:  begin mx = b_q; my = c_q; end
      default: begin mx = b_q; my = (op_q == OP_DIV) ? c_q : d_q; end
    endcase
  end
  assign prod = PROD_BITS'(mx.mag) * PROD_BITS'(my.mag);

  assign sum    = sadd(p0_q, p1_q);
  assign neg_qn = ~qn_q + PROD_BITS'(1);
  assign ovf    = (num_q.neg ? (qn_q > HALF) : (qn_q > HALF - PROD_BITS'(1))) ||
                  (div_q > HALF - PROD_BITS'(1));

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (num_q.mag),
    .b_i     (pd_q.mag),
    .done_o  (gcd_done),
    .gcd_o   (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    pd_d        = pd_q;
    num_d       = num_q;
    g_d         = g_q;
    qn_d        = qn_q;
    eq_d        = eq_q;
    st_d        = st_q;
    fnum_d      = fnum_q;
    fden_d      = fden_q;
    gcd_start   = 1'b0;
    div_start   = 1'b0;
    div_dvd     = num_q.mag;
    div_dvs     = gcd_g;
    out_valid_d = out_valid_q && out_stall_i;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_st_d    = out_st_q;
    out_eq_d    = out_eq_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_e'(op_i);
          a_d    = sa;
          b_d    = sb;
          c_d    = sc;
          d_d    = sd;
          // subtraction negates the right operand
          if (op_e'(op_i) == OP_SUB) c_d.neg = !sc.neg && (sc.mag != '0);
          eq_d   = (lhs_num_i == rhs_num_i) && (lhs_den_i == rhs_den_i);
          fnum_d = '0;
          fden_d = '0;
          priority if (sb.mag == '0 || sd.mag == '0) begin
            st_d    = ST_ZDEN;
            state_d = S_DONE;
          end else if (op_e'(op_i) == OP_DIV && sc.mag == '0) begin
            st_d    = ST_DIV0;
            state_d = S_DONE;
          end else begin
            st_d    = ST_OK;
            state_d = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        p0_d.mag = prod;
        p0_d.neg = (mx.neg ^ my.neg) && (prod != '0);
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        p1_d.mag = prod;
        p1_d.neg = (mx.neg ^ my.neg) && (prod != '0);
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        pd_d.mag = prod;
        pd_d.neg = (mx.neg ^ my.neg);
        state_d  = S_SUM;
      end
      S_SUM: begin
        num_d = (op_q == OP_ADD || op_q == OP_SUB) ? sum : p0_q;
        // sign of the denominator moves to the numerator
        if (pd_q.neg) num_d.neg = !num_d.neg && (num_d.mag != '0);
        if (num_d.mag == '0) begin
          fnum_d  = '0;
          fden_d  = (WORD_BITS-1)'(1);
          state_d = S_DONE;
        end else begin
          state_d = S_GST;
        end
      end
      S_GST: begin
        gcd_start = 1'b1;
        state_d   = S_GCD;
      end
      S_GCD: begin
        if (gcd_done) begin
          g_d       = gcd_g;
          div_start = 1'b1;
          state_d   = S_DVN;
        end
      end
      S_DVN: begin
        if (div_done) begin
          qn_d      = div_q;
          div_start = 1'b1;
          div_dvd   = pd_q.mag;
          div_dvs   = g_q;
          state_d   = S_DVD;
        end
      end
      S_DVD: begin
        if (div_done) begin
          if (ovf) begin
            st_d   = ST_OVF;
            fnum_d = '0;
            fden_d = '0;
          end else begin
            fnum_d = num_q.neg ? neg_qn[WORD_BITS-1:0] : qn_q[WORD_BITS-1:0];
            fden_d = div_q[WORD_BITS-2:0];
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait for a free output slot
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_num_d   = fnum_q;
          out_den_d   = fden_q;
          out_st_d    = st_q;
          out_eq_d    = eq_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
    d_q       <= d_d;
    p0_q      <= p0_d;
    p1_q      <= p1_d;
    pd_q      <= pd_d;
    num_q     <= num_d;
    g_q       <= g_d;
    qn_q      <= qn_d;
    eq_q      <= eq_d;
    st_q      <= st_d;
    fnum_q    <= fnum_d;
    fden_q    <= fden_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_st_q  <= out_st_d;
    out_eq_q  <= out_eq_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign res_num_o        = out_num_q;
  assign res_den_o        = out_den_q;
  assign status_o         = out_st_q;
  assign operands_equal_o = out_eq_q;

endmodule

// File: hdl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_checker import rau_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WORD_BITS-1:0] res_num_o,
  input logic [WORD_BITS-2:0] res_den_o,
  input logic [1:0]           status_o,
  input logic                 operands_equal_o
);

  `RAU_ASSERT_NXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o,
    "not busy after beat")
  `RAU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(res_num_o) && $stable(res_den_o) &&
    $stable(status_o) && $stable(operands_equal_o), "stalled result changed")
  `RAU_ASSERT_IMP(a_ok_den, out_valid_o && status_o == ST_OK, res_den_o != '0,
    "ok result with zero denominator")
  `RAU_ASSERT_IMP(a_err_zero, out_valid_o && status_o != ST_OK,
    res_num_o == '0 && res_den_o == '0, "error result not cleared")
  `RAU_ASSERT_IMP(a_zero_one, out_valid_o && status_o == ST_OK && res_num_o == '0,
    res_den_o == (WORD_BITS-1)'(1), "zero result not 0/1")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction beats under random idling and a long output hold-off, and
// checks every result beat against a sign-magnitude gcd predictor.
// ----------------------------------------------------------------------------
module tb;
  import rau_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int N_RANDOM = 1200;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    status_e     status;
    logic        eq;
  } fraction_res_t;

  typedef struct {
    op_e         op;
    logic [31:0] ln, ld, rn, rd;
    logic        has_res;
    fraction_res_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [31:0] lhs_num_i = '0, lhs_den_i = '0, rhs_num_i = '0, rhs_den_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0]  status_o;
  logic        operands_equal_o;

  rational_arithmetic_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fraction_res_t reduced_q[$];
  int  n_fail = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 18;
  int  recv_idle_pct = 87;
  bit  hold_off = 1'b0;

  // magnitude of a 32-bit two's complement word, zero-extended to 64 bits
  function automatic logic [63:0] mag_of(logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return {32'd0, m};
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact reduced result of one beat
  function automatic fraction_res_t reduce_fraction(op_e op, logic [31:0] ln,
      logic [31:0] ld, logic [31:0] rn, logic [31:0] rd);
    fraction_res_t r;
    logic [63:0] am, bm, cm, dm, pm, qm, nm, dnm, g;
    logic an, bn, cn, dn, pn, qn, nn;
    r = '0;
    r.status = ST_OK;
    r.eq = (ln == rn) && (ld == rd);
    am = mag_of(ln); bm = mag_of(ld); cm = mag_of(rn); dm = mag_of(rd);
    an = ln[31]; bn = ld[31]; cn = rn[31] ; dn = rd[31];
    if (bm == 0 || dm == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    if (op == OP_DIV && cm == 0) begin
      r.status = ST_DIV0;
      return r;
    end
    if (op == OP_SUB) cn = !cn && cm != 0;
    case (op)
      OP_ADD, OP_SUB: begin
        pm = am * dm; pn = (an != dn) && pm != 0;
        qm = bm * cm; qn = (bn != cn) && qm != 0;
        if (pn == qn) begin nm = pm + qm; nn = pn; end
        else if (pm >= qm) begin nm = pm - qm; nn = pn; end
        else begin nm = qm - pm; nn = qn; end
        dnm = bm * dm; qn = bn != dn;
      end
      OP_MUL: begin
        nm = am * cm; nn = an != cn;
        dnm = bm * dm; qn = bn != dn;
      end
      default: begin
        nm = am * dm; nn = an != dn;
        dnm = bm * cm; qn = bn != cn;
      end
    endcase
    if (qn) nn = !nn;
    g = gcd64(nm, dnm);
    nm = nm / g;
    dnm = dnm / g;
    if (nm == 0) nn = 1'b0;
    if ((nn ? nm > 64'h8000_0000 : nm > 64'h7fff_ffff) || dnm > 64'h7fff_ffff) begin
      r.status = ST_OVF;
    end else begin
      r.num = nn ? 32'(-nm) : 32'(nm);
      r.den = 31'(dnm);
    end
    return r;
  endfunction

  // random operand word biased toward small values and extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'($urandom_range(0, 1));
      3, 4:    return 32'($signed($urandom_range(0, 40)) - 20);
      5, 6:    return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom();
    endcase
  endfunction

  // drive one beat and wait until it is taken
  task automatic send_beat(op_e op, logic [31:0] ln, logic [31:0] ld,
      logic [31:0] rn, logic [31:0] rd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    lhs_num_i <= ln; lhs_den_i <= ld; rhs_num_i <= rn; rhs_den_i <= rd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reduced_q.push_back(reduce_fraction(op, ln, ld, rn, rd));
  endtask

  // receiver stall: random, or held for a long stretch on request
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // result checker, sampled at the edge
  always @(posedge clk_i) begin
    fraction_res_t e;
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reduced_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_fail++;
      end else begin
        e = reduced_q.pop_front();
        if (res_num_o !== e.num) begin
          $error("res_num exp %h got %h", e.num, res_num_o); n_fail++;
        end
        if (res_den_o !== e.den) begin
          $error("res_den exp %h got %h", e.den, res_den_o); n_fail++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); n_fail++;
        end
        if (operands_equal_o !== e.eq) begin
          $error("operands_equal exp %b got %b", e.eq, operands_equal_o); n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("rational_arithmetic_unit verification failed");
      $finish;
    end
  end

  stim_row_t rows[$];

  // table row; has_res set when the result is typed in
  task automatic add_row(op_e op, logic [31:0] ln, logic [31:0] ld, logic [31:0] rn,
      logic [31:0] rd, logic has_res = 0, logic [31:0] num = 0, logic [30:0] den = 0,
      status_e st = ST_OK, logic eq = 0);
    stim_row_t r;
    r.op = op; r.ln = ln; r.ld = ld; r.rn = rn; r.rd = rd;
    r.has_res = has_res;
    r.res = '{num: num, den: den, status: st, eq: eq};
    rows.push_back(r);
  endtask

  initial begin
    fraction_res_t e;
    int hold;
    // directed table: errors, zero result, extremes, overflow, each op
    add_row(OP_ADD, 1, 0, 1, 1, 1, 0, 0, ST_ZDEN, 0);
    add_row(OP_DIV, 1, 1, 0, 0, 1, 0, 0, ST_ZDEN, 0);
    add_row(OP_DIV, 5, 3, 0, 7, 1, 0, 0, ST_DIV0, 0);
    add_row(OP_SUB, 3, 4, 3, 4, 1, 0, 1, ST_OK, 1);
    add_row(OP_MUL, 0, -5, 9, 2, 1, 0, 1, ST_OK, 0);
    add_row(OP_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK, 0);
    add_row(OP_MUL, 32'h8000_0000, 1, -1, 1, 1, 0, 0, ST_OVF, 0);
    add_row(OP_DIV, 32'h8000_0000, 1, 1, 1, 1, 32'h8000_0000, 1, ST_OK, 0);
    add_row(OP_DIV, 1, 1, 1, 32'h8000_0000);
    add_row(OP_DIV, 1, 1, -7, 3);
    add_row(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    add_row(OP_SUB, 32'h7fff_ffff, 1, 32'h8000_0000, 1);
    add_row(OP_MUL, 32'h7fff_ffff, 3, 32'h8000_0000, 32'h7fff_ffff);
    add_row(OP_DIV, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
    add_row(OP_SUB, -6, -4, 10, 8);
    add_row(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'hdead_beef, 32'h1234_5678);
    add_row(OP_MUL, -1, -1, -1, -1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_beat(rows[i].op, rows[i].ln, rows[i].ld, rows[i].rn, rows[i].rd);
      if (rows[i].has_res) begin
        e = reduced_q.pop_back();
        if (e !== rows[i].res) begin
          $error("table row %0d: predictor %h, table %h", i, e, rows[i].res);
          n_fail++;
        end
        reduced_q.push_back(rows[i].res);
      end
    end

    // random beats over three idling phases; long hold-off early in the first
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin send_idle_pct = 87; recv_idle_pct = 18; end
      if (k == 2 * N_RANDOM / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (k == 20) begin
        hold_off = 1'b1;
        fork
          begin
            hold = 0;
            while (hold < 3000) begin @(posedge clk_i); hold++; end
            hold_off = 1'b0;
          end
        join_none
      end
      send_beat(op_e'($urandom_range(0, 3)), rand_word(), rand_word(),
                rand_word(), rand_word());
    end
    in_valid_i <= 1'b0;

    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (n_fail == 0 && reduced_q.size() == 0)
      $display("rational_arithmetic_unit verification clean");
    else
      $display("rational_arithmetic_unit verification failed");
    $finish;
  end
endmodule
